### rtl/kdel_pkg.sv
package kdel_pkg;

  localparam int unsigned NumButtons = 6;
  localparam int unsigned MaskW      = 6;
  localparam int unsigned CountW     = 8;
  localparam int unsigned OpW        = 3;
  localparam int unsigned ButtonW    = 3;

  localparam logic [CountW-1:0] DebounceReset = CountW'(4);

  typedef enum logic [OpW-1:0] {
    OpSample         = 3'd0,
    OpConsumePress   = 3'd1,
    OpConsumeRelease = 3'd2,
    OpClearEvents    = 3'd3,
    OpResync         = 3'd4
  } kdel_op_e;

  typedef struct packed {
    logic [OpW-1:0]     operation;
    logic [MaskW-1:0]   raw_levels;
    logic [ButtonW-1:0] button;
  } kdel_req_t;

  typedef struct packed {
    logic [MaskW-1:0] pressed_mask;
    logic             event_hit;
    logic [MaskW-1:0] press_pending;
    logic [MaskW-1:0] release_pending;
  } kdel_rsp_t;

endpackage

### rtl/kdel_if.sv
interface kdel_req_if;
  import kdel_pkg::*;

  logic               valid;
  logic               ready;
  logic [OpW-1:0]     operation;
  logic [MaskW-1:0]   raw_levels;
  logic [ButtonW-1:0] button;

  modport source (output valid, output operation, output raw_levels, output button,
                  input ready);
  modport sink   (input valid, input operation, input raw_levels, input button,
                  output ready);
endinterface

interface kdel_rsp_if;
  import kdel_pkg::*;

  logic             valid;
  logic             ready;
  logic [MaskW-1:0] pressed_mask;
  logic             event_hit;
  logic [MaskW-1:0] press_pending;
  logic [MaskW-1:0] release_pending;

  modport source (output valid, output pressed_mask, output event_hit,
                  output press_pending, output release_pending, input ready);
  modport sink   (input valid, input pressed_mask, input event_hit,
                  input press_pending, input release_pending, output ready);
endinterface

### rtl/kdel_core.sv
module kdel_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [kdel_pkg::CountW-1:0]   cfg_data_i,
  input  logic                          accept_i,
  input  kdel_pkg::kdel_req_t           req_i,
  output kdel_pkg::kdel_rsp_t           rsp_o
);
  import kdel_pkg::*;

  logic [CountW-1:0] samples_q;
  logic [MaskW-1:0]  stable_q, stable_d;
  logic [MaskW-1:0]  cand_q, cand_d;
  logic [CountW-1:0] count_q, count_d;
  logic [MaskW-1:0]  press_q, press_d;
  logic [MaskW-1:0]  rel_q, rel_d;
  logic              hit;
  logic [MaskW-1:0]  raw_pressed;
  logic [MaskW-1:0]  sel;
  logic              btn_ok;
  logic [MaskW-1:0]  changed;
  kdel_op_e          op;

  assign op          = kdel_op_e'(req_i.operation);
  assign raw_pressed = ~req_i.raw_levels;
  assign btn_ok      = 32'(req_i.button) < NumButtons;
  assign sel         = btn_ok ? (MaskW'(1) << req_i.button) : '0;

  always_comb begin
    stable_d = stable_q;
    cand_d   = cand_q;
    count_d  = count_q;
    press_d  = press_q;
    rel_d    = rel_q;
    hit      = 1'b0;
    changed  = '0;
    case (op)
      OpSample: begin
        if (raw_pressed == cand_q) begin
          if (count_q < samples_q) count_d = count_q + CountW'(1);
        end else begin
          cand_d  = raw_pressed;
          count_d = '0;
        end
        if (count_d >= samples_q && stable_q != cand_d) begin
          stable_d = cand_d;
          changed  = cand_d ^ stable_q;
          press_d  = press_q | (changed & cand_d);
          rel_d    = rel_q | (changed & stable_q);
        end
      end
      OpConsumePress: begin
        hit     = |(press_q & sel);
        press_d = press_q & ~sel;
      end
      OpConsumeRelease: begin
        hit   = |(rel_q & sel);
        rel_d = rel_q & ~sel;
      end
      OpClearEvents: begin
        press_d = '0;
        rel_d   = '0;
      end
      OpResync: begin
        stable_d = raw_pressed;
        cand_d   = raw_pressed;
        count_d  = '0;
        press_d  = '0;
        rel_d    = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      samples_q <= DebounceReset;
    end else if (cfg_we_i) begin
      samples_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q <= '0;
      cand_q   <= '0;
      count_q  <= '0;
      press_q  <= '0;
      rel_q    <= '0;
    end else if (accept_i) begin
      stable_q <= stable_d;
      cand_q   <= cand_d;
      count_q  <= count_d;
      press_q  <= press_d;
      rel_q    <= rel_d;
    end
  end

  assign rsp_o.pressed_mask    = stable_d;
  assign rsp_o.event_hit       = hit;
  assign rsp_o.press_pending   = press_d;
  assign rsp_o.release_pending = rel_d;

  // events are only ever raised on buttons whose stable level moved
  a_events_from_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && op == OpSample |=>
      ((press_q & ~$past(press_q)) & ~(stable_q & ~$past(stable_q))) == '0)
    else $error("press event without a released-to-pressed change");

  a_resync_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && op == OpResync |=> press_q == '0 && rel_q == '0 && count_q == '0)
    else $error("resync left events or count behind");

  a_stable_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && op != OpSample && op != OpResync |=> $stable(stable_q))
    else $error("stable mask moved on a non-sampling beat");

endmodule

### rtl/kdel_out_reg.sv
module kdel_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  kdel_pkg::kdel_rsp_t rsp_i,
  output logic                in_ready_o,
  kdel_rsp_if.source          rsp_o
);
  import kdel_pkg::*;

  logic      valid_q;
  kdel_rsp_t data_q;

  // take a new beat whenever the held one is empty or leaving
  assign in_ready_o = !valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) data_q <= rsp_i;
  end

  assign rsp_o.valid           = valid_q;
  assign rsp_o.pressed_mask    = data_q.pressed_mask;
  assign rsp_o.event_hit       = data_q.event_hit;
  assign rsp_o.press_pending   = data_q.press_pending;
  assign rsp_o.release_pending = data_q.release_pending;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !rsp_o.ready |-> !accept_i)
    else $error("input beat accepted over a stalled result");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !rsp_o.ready |=> valid_q && $stable(data_q))
    else $error("stalled result changed");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i |=> valid_q)
    else $error("accepted beat produced no result");

endmodule

### rtl/keypad_debounce_event_latch_unit.sv
// Keypad debouncer with sticky press/release event latches.
//
// Channels: req_i carries one operation per beat (sample tick, consume press,
// consume release, clear events, resync) with the raw active-low pins and a
// button index. rsp_o returns exactly one beat per request: the debounced
// mask, the consume hit flag and the pending press and release events.
// cfg_we_i/cfg_data_i write the debounce sample count; write it while idle.
//
// Each request's state update is one pass of mask compares and an 8-bit saturating
// count, registered into the result stage; its result shows in the next cycle.
// Throughput is one request per cycle while the receiver takes results, set by the state loop.
//
// Reset clears the debounced, candidate and event masks and the count, and
// sets the sample count to 4. When the receiver stalls the result register
// holds its beat and req_i.ready drops; it rises again in the cycle the
// result is taken, so no bubble is added.
module keypad_debounce_event_latch_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [kdel_pkg::CountW-1:0] cfg_data_i,
  kdel_req_if.sink                    req_i,
  kdel_rsp_if.source                  rsp_o
);
  import kdel_pkg::*;

  logic      in_ready;
  logic      accept;
  kdel_req_t req;
  kdel_rsp_t rsp_next;

  assign req_i.ready    = in_ready;
  assign accept         = req_i.valid && in_ready;
  assign req.operation  = req_i.operation;
  assign req.raw_levels = req_i.raw_levels;
  assign req.button     = req_i.button;

  kdel_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .req_i      (req),
    .rsp_o      (rsp_next)
  );

  kdel_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .rsp_i      (rsp_next),
    .in_ready_o (in_ready),
    .rsp_o      (rsp_o)
  );

endmodule

### sim/tb.sv
module tb;
  import kdel_pkg::*;

  localparam logic [OpW-1:0] OpSpare5 = 3'd5;
  localparam logic [OpW-1:0] OpSpare7 = 3'd7;

  localparam kdel_rsp_t Quiet     = '0;
  localparam kdel_rsp_t AllDown   = '{6'h3F, 1'b0, 6'h00, 6'h00};

  typedef struct packed {
    bit                 cfg_row;
    logic [CountW-1:0]  cfg_val;
    logic [OpW-1:0]     op;
    logic [MaskW-1:0]   raw;
    logic [ButtonW-1:0] btn;
    bit                 typed;
    kdel_rsp_t          want;
  } plan_row_t;

  localparam int PlanLen = 27;
  localparam plan_row_t Plan [PlanLen] = '{
    '{1'b0, 8'd0,   OpSample,         6'h3F, 3'd0, 1'b1, Quiet},
    '{1'b0, 8'd0,   OpConsumePress,   6'h3F, 3'd7, 1'b1, Quiet},
    '{1'b0, 8'd0,   OpConsumeRelease, 6'h3F, 3'd6, 1'b1, Quiet},
    '{1'b0, 8'd0,   OpSpare5,         6'h00, 3'd0, 1'b1, Quiet},
    '{1'b0, 8'd0,   OpSpare7,         6'h3F, 3'd7, 1'b1, Quiet},
    '{1'b0, 8'd0,   OpResync,         6'h00, 3'd0, 1'b1, AllDown},
    '{1'b0, 8'd0,   OpSample,         6'h3F, 3'd0, 1'b0, Quiet},
    '{1'b0, 8'd0,   OpSample,         6'h3F, 3'd1, 1'b0, Quiet},
    '{1'b0, 8'd0,   OpSample,         6'h3F, 3'd2, 1'b0, Quiet},
    '{1'b0, 8'd0,   OpSample,         6'h3F, 3'd3, 1'b0, Quiet},
    '{1'b0, 8'd0,   OpSample,         6'h3F, 3'd4, 1'b0, Quiet},
    '{1'b0, 8'd0,   OpConsumeRelease, 6'h3F, 3'd0, 1'b0, Quiet},
    '{1'b0, 8'd0,   OpConsumeRelease, 6'h3F, 3'd5, 1'b0, Quiet},
    '{1'b0, 8'd0,   OpConsumeRelease, 6'h3F, 3'd0, 1'b0, Quiet},
    '{1'b0, 8'd0,   OpConsumePress,   6'h3F, 3'd3, 1'b0, Quiet},
    '{1'b0, 8'd0,   OpClearEvents,    6'h3F, 3'd0, 1'b1, Quiet},
    '{1'b1, 8'd0,   OpSample,         6'h00, 3'd0, 1'b0, Quiet},
    '{1'b0, 8'd0,   OpSample,         6'h2A, 3'd0, 1'b0, Quiet},
    '{1'b0, 8'd0,   OpSample,         6'h15, 3'd0, 1'b0, Quiet},
    '{1'b0, 8'd0,   OpConsumePress,   6'h15, 3'd1, 1'b0, Quiet},
    '{1'b0, 8'd0,   OpConsumeRelease, 6'h15, 3'd0, 1'b0, Quiet},
    '{1'b1, 8'd255, OpSample,         6'h00, 3'd0, 1'b0, Quiet},
    '{1'b0, 8'd0,   OpSample,         6'h00, 3'd0, 1'b0, Quiet},
    '{1'b0, 8'd0,   OpSample,         6'h00, 3'd0, 1'b0, Quiet},
    '{1'b0, 8'd0,   OpSample,         6'h00, 3'd0, 1'b0, Quiet},
    '{1'b0, 8'd0,   OpResync,         6'h3F, 3'd0, 1'b1, Quiet},
    '{1'b0, 8'd0,   OpSample,         6'h3F, 3'd0, 1'b0, Quiet}
  };

  localparam logic [CountW-1:0] PhaseSamples [8] = '{
    8'd4, 8'd1, 8'd0, 8'd2, 8'd255, 8'd7, 8'd3, 8'd4
  };

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CountW-1:0] cfg_data;

  kdel_req_if req_if ();
  kdel_rsp_if rsp_if ();

  keypad_debounce_event_latch_unit u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .req_i      (req_if.sink),
    .rsp_o      (rsp_if.source)
  );

  // predictor state
  logic [CountW-1:0] samples;
  logic [MaskW-1:0]  stable_q;
  logic [MaskW-1:0]  cand_q;
  logic [CountW-1:0] count_q;
  logic [MaskW-1:0]  press_ev;
  logic [MaskW-1:0]  release_ev;

  kdel_rsp_t status_due [$];
  int        errors;
  bit        idle_on;
  bit        cur_typed;
  kdel_rsp_t cur_want;
  logic [MaskW-1:0] held_raw;

  function automatic kdel_rsp_t keypad_step(logic [OpW-1:0] op, logic [MaskW-1:0] raw,
                                            logic [ButtonW-1:0] btn);
    logic [MaskW-1:0] pins;
    logic [MaskW-1:0] prev;
    logic [MaskW-1:0] changed;
    logic [MaskW-1:0] bitsel;
    logic             hit;
    kdel_rsp_t        r;
    pins   = ~raw;
    hit    = 1'b0;
    bitsel = MaskW'(1) << btn;
    case (op)
      OpSample: begin
        if (pins == cand_q) begin
          if (count_q < samples) count_q = count_q + 8'd1;
        end else begin
          cand_q  = pins;
          count_q = '0;
        end
        if (count_q >= samples && stable_q != cand_q) begin
          prev       = stable_q;
          stable_q   = cand_q;
          changed    = stable_q ^ prev;
          press_ev   = press_ev | (changed & stable_q);
          release_ev = release_ev | (changed & prev);
        end
      end
      OpConsumePress: begin
        if (btn < NumButtons && (press_ev & bitsel) != '0) begin
          press_ev = press_ev & ~bitsel;
          hit      = 1'b1;
        end
      end
      OpConsumeRelease: begin
        if (btn < NumButtons && (release_ev & bitsel) != '0) begin
          release_ev = release_ev & ~bitsel;
          hit        = 1'b1;
        end
      end
      OpClearEvents: begin
        press_ev   = '0;
        release_ev = '0;
      end
      OpResync: begin
        stable_q   = pins;
        cand_q     = pins;
        count_q    = '0;
        press_ev   = '0;
        release_ev = '0;
      end
      default: ;
    endcase
    r.pressed_mask    = stable_q;
    r.event_hit       = hit;
    r.press_pending   = press_ev;
    r.release_pending = release_ev;
    return r;
  endfunction

  task automatic push_beat(logic [OpW-1:0] op, logic [MaskW-1:0] raw,
                           logic [ButtonW-1:0] btn, bit typed, kdel_rsp_t want);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.operation  <= op;
    req_if.raw_levels <= raw;
    req_if.button     <= btn;
    cur_typed         <= typed;
    cur_want          <= want;
    do @(posedge clk); while (!req_if.ready);
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (status_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_samples(logic [CountW-1:0] v);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    samples  = v;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Mostly clean holds of one level long enough to be accepted; the rest are
  // short holds, single-sample glitches, the event operations, resyncs and spare opcodes.
  task automatic run_phase(int budget);
    int               sent;
    int               len;
    int               pick;
    logic [MaskW-1:0] lvl;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        case ($urandom_range(0, 3))
          0:       lvl = MaskW'($urandom);
          3:       lvl = held_raw;
          default: lvl = held_raw ^ (MaskW'(1) << $urandom_range(0, 5));
        endcase
        held_raw = lvl;
        if ($urandom_range(0, 4) == 0) len = $urandom_range(1, int'(samples) + 1);
        else len = int'(samples) + 1 + $urandom_range(0, 3);
        repeat (len) push_beat(OpSample, lvl, ButtonW'($urandom), 1'b0, Quiet);
        sent += len;
      end else begin
        if (pick < 65)
          push_beat(OpSample, MaskW'($urandom), ButtonW'($urandom), 1'b0, Quiet);
        else if (pick < 80)
          push_beat(OpConsumePress, MaskW'($urandom), ButtonW'($urandom), 1'b0, Quiet);
        else if (pick < 93)
          push_beat(OpConsumeRelease, MaskW'($urandom), ButtonW'($urandom), 1'b0, Quiet);
        else if (pick < 96)
          push_beat(OpClearEvents, MaskW'($urandom), ButtonW'($urandom), 1'b0, Quiet);
        else if (pick < 98) begin
          held_raw = MaskW'($urandom);
          push_beat(OpResync, held_raw, ButtonW'($urandom), 1'b0, Quiet);
        end else
          push_beat(OpW'(int'(OpSpare5) + $urandom_range(0, 2)), MaskW'($urandom),
                    ButtonW'($urandom), 1'b0, Quiet);
        sent++;
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("tb: FAIL");
    $finish;
  end

  // result-side back-pressure
  initial begin
    rsp_if.ready = 1'b1;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 4) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : status_check
    kdel_rsp_t seen;
    kdel_rsp_t want;
    if (rst_n) begin
      if (rsp_if.valid && rsp_if.ready) begin
        seen = '{rsp_if.pressed_mask, rsp_if.event_hit, rsp_if.press_pending,
                 rsp_if.release_pending};
        if (status_due.size() == 0) begin
          if (errors < 10)
            $display("unexpected status beat: mask %h hit %b press %h release %h",
                     seen.pressed_mask, seen.event_hit, seen.press_pending,
                     seen.release_pending);
          errors++;
        end else begin
          want = status_due.pop_front();
          if (seen.pressed_mask !== want.pressed_mask || seen.event_hit !== want.event_hit ||
              seen.press_pending !== want.press_pending ||
              seen.release_pending !== want.release_pending) begin
            if (errors < 10)
              $display("status mismatch: want %h/%b/%h/%h got %h/%b/%h/%h",
                       want.pressed_mask, want.event_hit, want.press_pending,
                       want.release_pending, seen.pressed_mask, seen.event_hit,
                       seen.press_pending, seen.release_pending);
            errors++;
          end
        end
      end
      // advance the predictor on every accepted request beat
      if (req_if.valid && req_if.ready) begin
        want = keypad_step(req_if.operation, req_if.raw_levels, req_if.button);
        status_due.push_back(cur_typed ? cur_want : want);
      end
    end
  end

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_data          = '0;
    req_if.valid      = 1'b0;
    req_if.operation  = OpSample;
    req_if.raw_levels = '1;
    req_if.button     = '0;
    cur_typed         = 1'b0;
    cur_want          = Quiet;
    idle_on           = 1'b1;
    errors            = 0;
    held_raw          = '1;
    samples           = DebounceReset;
    stable_q          = '0;
    cand_q            = '0;
    count_q           = '0;
    press_ev          = '0;
    release_ev        = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (Plan[i]) begin
      if (Plan[i].cfg_row) begin
        wait_drained();
        write_samples(Plan[i].cfg_val);
      end else begin
        push_beat(Plan[i].op, Plan[i].raw, Plan[i].btn, Plan[i].typed, Plan[i].want);
      end
    end

    held_raw = 6'h3F;
    for (int i = 0; i < 8; i++) begin
      wait_drained();
      write_samples(i == 5 ? CountW'($urandom_range(5, 40)) : PhaseSamples[i]);
      // drop all idling for the closing phases
      idle_on = (i < 6);
      run_phase(PhaseSamples[i] == 8'd255 ? 257 : 30);
    end

    wait_drained();
    repeat (4) @(posedge clk);
    if (errors == 0 && status_due.size() == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule
